// ----- rtl/dap_pkg.sv -----
// shared types and codes for the abbreviation stream parser
// used by the decoder, the output queue, the top level and the checker
`default_nettype none

package dap_pkg;

    localparam int DataW  = 64;
    localparam int TdataW = 136;   // 132 bits of fields padded to whole bytes

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_PAIR      = 3'd1,
        KIND_ENTRY_END = 3'd2,
        KIND_TABLE_END = 3'd3,
        KIND_ERROR     = 3'd4
    } dap_kind_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_CHILDREN  = 3'd1;
    localparam logic [2:0] ERR_EARLY_END = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    localparam logic [3:0] LEB_LAST_BYTE = 4'd9;

    typedef enum logic [4:0] {
        PH_CODE  = 5'b00001,
        PH_TAG   = 5'b00010,
        PH_CHILD = 5'b00100,
        PH_NAME  = 5'b01000,
        PH_FORM  = 5'b10000
    } dap_phase_t;

    typedef struct packed {
        dap_kind_t        kind;
        logic [DataW-1:0] first_value;
        logic [DataW-1:0] second_value;
        logic             has_children;
        logic [2:0]       error_code;
    } dap_rec_t;

    // records caused by one byte: a full first record and an optional error after it
    typedef struct packed {
        logic       valid;
        dap_rec_t   rec0;
        logic       two;
        logic [2:0] err1;
    } dap_pair_t;

endpackage

`default_nettype wire

// ----- rtl/dwarf_abbrev_stream_parser.sv -----
// abbreviation section parser: one byte per request in, decoded records out
// the records of a byte are registered in the result queue before they show on the master side
// throughput: one byte per cycle while s_tready is high; a byte giving two records holds the output
// for both, and the two-slot result queue drops s_tready only when both slots are full
// reset: aresetn synchronous active low, clears the parse state and empties the queue
// depends on dap_pkg, dap_decoder, dap_out_queue
`default_nettype none

module dwarf_abbrev_stream_parser
    import dap_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input stream of section bytes
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] data_byte
    input  wire logic              s_tlast,   // section_last
    // result stream of records
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [TdataW-1:0]      m_tdata,   // [63:0] first_value, [127:64] second_value,
                                              // [128] has_children, [131:129] error_code,
                                              // [135:132] zero
    output logic [2:0]             m_tuser,   // record_kind
    output logic                   m_tlast    // run_last
);

    logic      accept;
    dap_pair_t pair;
    dap_rec_t  rec;

    // a request is taken whenever the queue can absorb two more records
    assign accept = s_tvalid && s_tready;

    // parse state lives here; records come out combinationally for the byte on the port
    dap_decoder u_dec (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_tdata),
        .section_last (s_tlast),
        .pair         (pair)
    );

    // bytes that produce nothing never enter the queue
    dap_out_queue u_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && pair.valid),
        .push_pair (pair),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_rec   (rec),
        .out_last  (m_tlast)
    );

    // pack the record onto the bus
    assign m_tuser = rec.kind;
    assign m_tdata = {4'b0000, rec.error_code, rec.has_children,
                      rec.second_value, rec.first_value};

endmodule

`default_nettype wire

// ----- rtl/dap_decoder.sv -----
// parse state and per-byte record generation
// depends on dap_pkg
`default_nettype none

module dap_decoder
    import dap_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] data_byte,
    input  wire logic       section_last,
    output dap_pair_t       pair
);

    dap_phase_t       phase_reg, phase_next;
    logic [DataW-1:0] acc_reg, acc_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [DataW-1:0] code_reg, code_next;
    logic [DataW-1:0] name_reg, name_next;
    logic             ignore_reg, ignore_next;

    logic [6:0]       shamt;
    logic [DataW-1:0] merged;
    logic             leb_over;
    logic             leb_done;
    logic             rec_hit;
    logic             fail;
    logic             tab_end;
    dap_rec_t         rec;

    assign shamt    = {cnt_reg, 3'b000} - {3'b000, cnt_reg};
    assign merged   = acc_reg | ({{(DataW-7){1'b0}}, data_byte[6:0]} << shamt);
    assign leb_over = (cnt_reg > LEB_LAST_BYTE)
                   || ((cnt_reg == LEB_LAST_BYTE) && (data_byte[7:1] != 7'd0));
    assign leb_done = !data_byte[7];

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        code_next   = code_reg;
        name_next   = name_reg;
        ignore_next = ignore_reg;
        rec_hit     = 1'b0;
        fail        = 1'b0;
        tab_end     = 1'b0;
        rec         = '{kind: KIND_ERROR, first_value: '0, second_value: '0,
                        has_children: 1'b0, error_code: ERR_NONE};
        pair        = '0;

        if (!ignore_reg) begin
            if (phase_reg == PH_CHILD) begin
                rec_hit = 1'b1;
                if (data_byte[7:1] == 7'd0) begin
                    rec.kind         = KIND_HEADER;
                    rec.first_value  = code_reg;
                    rec.second_value = name_reg;
                    rec.has_children = data_byte[0];
                    phase_next       = PH_NAME;
                end else begin
                    rec.error_code = ERR_CHILDREN;
                    fail           = 1'b1;
                end
            end else if (leb_over) begin
                rec_hit        = 1'b1;
                rec.error_code = ERR_OVERFLOW;
                fail           = 1'b1;
            end else if (!leb_done) begin
                acc_next = merged;
                cnt_next = cnt_reg + 4'd1;
            end else begin
                acc_next = '0;
                cnt_next = '0;
                case (phase_reg)
                    PH_CODE: begin
                        if (merged == '0) begin
                            rec_hit  = 1'b1;
                            rec.kind = KIND_TABLE_END;
                            tab_end  = 1'b1;
                        end else begin
                            code_next  = merged;
                            phase_next = PH_TAG;
                        end
                    end
                    PH_TAG: begin
                        name_next  = merged;
                        phase_next = PH_CHILD;
                    end
                    PH_NAME: begin
                        name_next  = merged;
                        phase_next = PH_FORM;
                    end
                    PH_FORM: begin
                        rec_hit = 1'b1;
                        if (name_reg == '0 && merged == '0) begin
                            rec.kind   = KIND_ENTRY_END;
                            phase_next = PH_CODE;
                        end else begin
                            rec.kind         = KIND_PAIR;
                            rec.first_value  = name_reg;
                            rec.second_value = merged;
                            phase_next       = PH_NAME;
                        end
                    end
                    default: phase_next = PH_CODE;
                endcase
            end

            // follow-up error: early table end, or section closing an open table
            pair.rec0 = rec;
            if (tab_end && !section_last) begin
                pair.two  = 1'b1;
                pair.err1 = ERR_EARLY_END;
            end else if (section_last && !tab_end && !fail) begin
                if (rec_hit) begin
                    pair.two  = 1'b1;
                    pair.err1 = ERR_TRUNCATED;
                end else begin
                    pair.rec0.error_code = ERR_TRUNCATED;
                end
            end
            pair.valid  = rec_hit || section_last;
            ignore_next = fail || tab_end;
            if (section_last && !tab_end && !fail) begin
                pair.valid = 1'b1;
            end else if (section_last && (tab_end || fail)) begin
                pair.valid = 1'b1;
            end
        end

        if (section_last) begin
            phase_next  = PH_CODE;
            acc_next    = '0;
            cnt_next    = '0;
            code_next   = '0;
            name_next   = '0;
            ignore_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_CODE;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            code_reg   <= '0;
            name_reg   <= '0;
            ignore_reg <= 1'b0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            code_reg   <= code_next;
            name_reg   <= name_next;
            ignore_reg <= ignore_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dap_out_queue.sv -----
// two-slot result queue, each slot holds the records of one byte
// depends on dap_pkg
`default_nettype none

module dap_out_queue
    import dap_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire dap_pair_t push_pair,
    output logic           has_room,
    output logic           out_valid,
    input  wire logic      out_ready,
    output dap_rec_t       out_rec,
    output logic           out_last
);

    dap_pair_t slot0_reg, slot0_next;
    dap_pair_t slot1_reg, slot1_next;
    logic      v0_reg, v0_next;
    logic      v1_reg, v1_next;
    logic      sel_reg, sel_next;
    logic      pop;
    logic      slot_done;

    assign has_room  = !v1_reg;
    assign out_valid = v0_reg;
    assign pop       = v0_reg && out_ready;
    assign slot_done = pop && (sel_reg || !slot0_reg.two);

    always_comb begin
        out_rec  = slot0_reg.rec0;
        out_last = !slot0_reg.two;
        if (sel_reg) begin
            out_rec  = '{kind: KIND_ERROR, first_value: '0, second_value: '0,
                         has_children: 1'b0, error_code: slot0_reg.err1};
            out_last = 1'b1;
        end
    end

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        sel_next   = sel_reg;
        if (slot_done) begin
            slot0_next = slot1_reg;
            v0_next    = v1_reg;
            v1_next    = 1'b0;
            sel_next   = 1'b0;
        end else if (pop) begin
            sel_next = 1'b1;
        end
        if (push) begin
            if (!v0_next) begin
                slot0_next = push_pair;
                v0_next    = 1'b1;
            end else begin
                slot1_next = push_pair;
                v1_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end else begin
            v0_reg  <= v0_next;
            v1_reg  <= v1_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ----- rtl/dap_checker.sv -----
// port-level checks for the abbreviation stream parser, bound to the top level
// depends on dap_pkg
`default_nettype none

module dap_checker
    import dap_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic [7:0]        s_tdata,
    input wire logic              s_tlast,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [TdataW-1:0] m_tdata,
    input wire logic [2:0]        m_tuser,
    input wire logic              m_tlast
);

    // output stays put while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed under stall");

    // error records carry a code, others none
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[131:129] != ERR_NONE)))
        else $error("error code does not match record kind");

    // children flag only on headers
    a_children: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_HEADER |-> !m_tdata[128])
        else $error("children flag outside header");

    // a table end that is not the run's end is followed by the early-end error
    a_early: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_TABLE_END && !m_tlast
        |=> m_tvalid && m_tuser == KIND_ERROR && m_tdata[131:129] == ERR_EARLY_END)
        else $error("table end not followed by early-end error");

    // nothing on the output right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind dwarf_abbrev_stream_parser dap_checker u_chk (.*);

`default_nettype wire
